// File: design/double_hash_open_address_table_core_defines.svh
// Assertion macros for the double-hash table core.
// Included by the top level; depends on nothing else.
`ifndef DOUBLE_HASH_OPEN_ADDRESS_TABLE_CORE_DEFINES_SVH
`define DOUBLE_HASH_OPEN_ADDRESS_TABLE_CORE_DEFINES_SVH
// Assert that an implication holds at every clock edge outside reset.
`define DH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Assert that a condition holds at every clock edge outside reset.
`define DH_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);
`endif

// File: design/dhoat_pkg.sv
// Shared types and codes for the double-hash table core.
// No dependencies.
package dhoat_pkg;
  // Number of buckets; a prime so that every nonzero step visits the whole table.
  localparam int TABLE_SIZE = 1021;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic CFG_STEP_PRIME = 1'b0;
  localparam logic CFG_MAX_FILL   = 1'b1;

  // Operation as it leaves the front end.
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [31:0] key_hash;
  } dhoat_op_t;
endpackage

// File: design/double_hash_open_address_table_core.sv
// Top level of the double-hash table core: config registers, front, back.
// Depends on dhoat_pkg, dhoat_front, dhoat_back and the defines header.
//
// Use: operations enter on s_axis (tdata = mode, key, key_hash), one result
// per operation leaves on m_axis (tdata = status, bucket, stored_count).
// Registers step_prime (index 0) and max_fill (index 1) are written on the
// cfg channel while the block is idle; cfg_ready is low while an operation
// is queued or in progress.
// The remainder is computed one hash bit a cycle; each probe of the bucket
// memory then passes through a read state and a check state (S_RD, S_CHK);
// a few probes at half load, up to TABLE_SIZE probes worst case.
// One operation is in the back end at a time; the front queue holds two.
// After reset a clearing pass marks all buckets empty, during which no
// operation starts. A stalled receiver holds the result register, and the
// next finished result waits until it is taken.
`include "double_hash_open_address_table_core_defines.svh"
module double_hash_open_address_table_core
  import dhoat_pkg::*;
#(
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // mode[1:0], key[33:2], key_hash[65:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // status[2:0], bucket[12:3], stored_count[22:13]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);
  logic [9:0] step_prime, max_fill;
  logic op_valid, op_ready, busy;
  dhoat_op_t op;
  logic [2:0] st;
  logic [9:0] bk, cn;

  assign cfg_ready = !busy && !op_valid;
  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_prime <= 10'd29;
      max_fill <= 10'd510;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_PRIME: step_prime <= cfg_data;
        CFG_MAX_FILL:   max_fill <= cfg_data;
        default: ;
      endcase
    end
  end

  dhoat_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_mode(s_axis_tdata[1:0]), .in_key(s_axis_tdata[33:2]),
    .in_hash(s_axis_tdata[65:34]), .op_valid, .op_ready, .op
  );

  dhoat_back #(.KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst, .op_valid, .op_ready, .op, .step_prime, .max_fill,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_status(st), .res_bucket(bk), .res_count(cn), .busy
  );
  assign m_axis_tdata = {1'b0, cn, bk, st};

  // Checks.
  `DH_ASSERT_ALWAYS(a_status_range, !m_axis_tvalid || st <= ST_FULL, "bad status")
  `DH_ASSERT_IMPL(a_bucket_range, m_axis_tvalid, bk < 10'(TABLE_SIZE), "bucket out of range")
  `DH_ASSERT_IMPL(a_count_limit, m_axis_tvalid, cn <= 10'(TABLE_SIZE), "count too big")
endmodule

// File: design/dhoat_front.sv
// Front end: accepts operations, normalizes mode and key, and queues them.
// Depends on dhoat_pkg.
module dhoat_front
  import dhoat_pkg::*;
#(
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_hash,
  output logic        op_valid,
  input  logic        op_ready,
  output dhoat_op_t   op
);
  localparam int QD = 2;
  dhoat_op_t  q [QD];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;
  dhoat_op_t  nop;
  logic [63:0] mask;

  assign mask = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

  // Classify: mode three becomes a lookup, key is masked.
  always_comb begin
    nop.mode = (in_mode == 2'd3) ? MODE_LOOKUP : in_mode;
    nop.key = {32'd0, in_key} & mask;
    nop.key_hash = in_hash;
  end

  assign in_ready = (cnt != 2'(QD));
  assign push = in_valid && in_ready;
  assign op_valid = (cnt != 2'd0);
  assign pop = op_valid && op_ready;
  assign op = q[rp];

  // Two-entry queue between front and back.
  always_ff @(posedge clk) begin
    if (push) q[wp] <= nop;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: design/dhoat_back.sv
// Back end: probe engine over the bucket memory, with result register.
// Depends on dhoat_pkg.
module dhoat_back
  import dhoat_pkg::*;
#(
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  dhoat_op_t   op,
  input  logic [9:0]  step_prime,
  input  logic [9:0]  max_fill,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [2:0]  res_status,
  output logic [9:0]  res_bucket,
  output logic [9:0]  res_count,
  output logic        busy
);
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int HW = 32;
  localparam logic [AW:0] TS = (AW+1)'(TABLE_SIZE);
  // 2^AW modulo the table size, used to fold the high hash bits down.
  localparam int FC = (2 ** AW) % TABLE_SIZE;
  localparam logic [AW-1:0] FOLD_C = AW'(FC);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_MOD = 4'd2,
    S_STEP = 4'd3, S_RD = 4'd4, S_CHK = 4'd5, S_WR = 4'd6, S_OUT = 4'd7;
  logic [3:0] state;

  logic [1:0]  mark_mem [TABLE_SIZE];
  logic [KEY_BITS-1:0] key_mem [TABLE_SIZE];
  logic [1:0]  rd_mark;
  logic [KEY_BITS-1:0] rd_key;

  logic [1:0]  mode;
  logic [KEY_BITS-1:0] key;
  logic [HW-1:0] hsh;
  logic [HW-1:0] rem_a, rem_b;
  logic [5:0]  bit_i;
  logic [AW-1:0] pos, step, tomb, slot;
  logic        have_tomb;
  logic [CW-1:0] nprobe;
  logic [CW-1:0] count;
  logic [AW-1:0] clr;
  logic        wr_en;
  logic [1:0]  wr_mark;
  logic [9:0]  prime;
  logic [2:0]  status;
  logic [9:0]  bkt;

  assign prime = (step_prime == 10'd0) ? 10'd1 : step_prime;
  assign op_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);

  // Restoring-division remainder step for the prime, one hash bit per cycle.
  logic [HW:0] tb;
  always_comb begin
    tb = {rem_b, hsh[bit_i[4:0]]};
  end

  // Fold for the remainder by the table size: high bits times 2^AW mod size.
  logic [HW-1:0] fold_a;
  assign fold_a = HW'(rem_a[HW-1:AW] * FOLD_C) + HW'(rem_a[AW-1:0]);

  // Probe step: (prime - hash mod prime) modulo the table size.
  logic [AW:0] bm;
  logic [9:0] stp;
  always_comb begin
    stp = prime - 10'(rem_b);
    bm = (AW+1)'(stp);
    if (bm >= TS) bm = bm - TS;
  end

  // pos + step modulo size.
  logic [AW:0] psum;
  assign psum = {1'b0, pos} + {1'b0, step};

  // Memory: synchronous read, single write.
  logic [AW-1:0] mem_wa;
  logic [KEY_BITS-1:0] mem_wk;
  logic mem_wkey;
  always_ff @(posedge clk) begin
    rd_mark <= mark_mem[pos];
    rd_key  <= key_mem[pos];
    if (wr_en) mark_mem[mem_wa] <= wr_mark;
    if (mem_wkey) key_mem[mem_wa] <= mem_wk;
  end
  assign mem_wa = (state == S_CLEAR) ? clr : slot;
  assign mem_wk = key;
  assign wr_en = (state == S_CLEAR) || (state == S_WR);
  assign wr_mark = (state == S_CLEAR) ? MARK_EMPTY :
                   (mode == MODE_INSERT) ? MARK_USED : MARK_TOMB;
  assign mem_wkey = (state == S_WR) && (mode == MODE_INSERT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_OUT) res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(TABLE_SIZE - 1)) state <= S_IDLE;
        end
        S_IDLE: if (op_valid) begin
          mode <= op.mode;
          key <= KEY_BITS'(op.key);
          hsh <= op.key_hash;
          rem_a <= op.key_hash;
          rem_b <= '0;
          bit_i <= 6'd31;
          have_tomb <= 1'b0;
          nprobe <= '0;
          if (op.mode == MODE_INSERT && {{(11-CW){1'b0}}, count} > {1'b0, max_fill}) begin
            status <= ST_FULL; bkt <= '0; state <= S_OUT;
          end else if (op.mode != MODE_INSERT && count == '0) begin
            status <= ST_NOT_FOUND; bkt <= '0; state <= S_OUT;
          end else state <= S_MOD;
        end
        S_MOD: begin
          if (rem_a >= HW'(2 ** AW)) rem_a <= fold_a;
          else if (rem_a >= HW'(TABLE_SIZE)) rem_a <= rem_a - HW'(TABLE_SIZE);
          rem_b <= (tb >= {23'd0, prime}) ? HW'(tb - {23'd0, prime}) : HW'(tb);
          bit_i <= bit_i - 6'd1;
          if (bit_i == 6'd0) state <= S_STEP;
        end
        S_STEP: begin
          step <= AW'(bm);
          pos <= AW'(rem_a);
          state <= S_RD;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          nprobe <= nprobe + CW'(1);
          if (rd_mark == MARK_EMPTY) begin
            if (mode == MODE_INSERT) begin
              slot <= have_tomb ? tomb : pos; state <= S_WR;
            end else begin
              status <= ST_NOT_FOUND; bkt <= '0; state <= S_OUT;
            end
          end else if (rd_mark == MARK_USED && rd_key == key) begin
            bkt <= 10'(pos);
            if (mode == MODE_INSERT) begin
              status <= ST_DUPLICATE; state <= S_OUT;
            end else if (mode == MODE_REMOVE) begin
              slot <= pos; state <= S_WR;
            end else begin
              status <= ST_FOUND; state <= S_OUT;
            end
          end else begin
            if (rd_mark == MARK_TOMB && !have_tomb) begin
              have_tomb <= 1'b1; tomb <= pos;
            end
            pos <= (psum >= TS) ? AW'(psum - TS) : AW'(psum);
            if (nprobe == CW'(TABLE_SIZE - 1)) begin
              if (mode == MODE_INSERT && (have_tomb || rd_mark == MARK_TOMB)) begin
                slot <= have_tomb ? tomb : pos; state <= S_WR;
              end else begin
                status <= (mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
                bkt <= '0; state <= S_OUT;
              end
            end else state <= S_RD;
          end
        end
        S_WR: begin
          bkt <= 10'(slot);
          if (mode == MODE_INSERT) begin
            count <= count + CW'(1); status <= ST_INSERTED;
          end else begin
            count <= count - CW'(1); status <= ST_REMOVED;
          end
          state <= S_OUT;
        end
        // Load the result register once the previous result has been taken.
        S_OUT: if (!res_valid || res_ready) begin
          res_valid <= 1'b1;
          res_status <= status;
          res_bucket <= bkt;
          res_count <= 10'(count);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: test/double_hash_open_address_table_core_tb.sv
// Self-checking testbench for the double-hash open-address table core.
// Depends on dhoat_pkg and double_hash_open_address_table_core; it holds its own table model.
module double_hash_open_address_table_core_tb;
  import dhoat_pkg::*;

  localparam int NUM_BUCKETS = 1021;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] key_hash;
  } table_op_t;

  typedef struct {
    logic [2:0] status;
    logic [9:0] bucket;
    logic [9:0] count;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // mode[1:0], key[33:2], key_hash[65:34]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // status[2:0], bucket[12:3], stored_count[22:13]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_STEP_PRIME;
  logic [9:0]  cfg_data = '0;

  // Shadow copy of the table and its registers.
  logic [1:0]   shadow_mark [NUM_BUCKETS];
  logic [31:0]  shadow_key [NUM_BUCKETS];
  int unsigned  shadow_count = 0;
  logic [9:0]   shadow_step_prime = 10'd29;
  logic [9:0]   shadow_max_fill = 10'd510;

  table_op_t    pending_ops[$];
  table_reply_t expected_replies[$];
  int           failures = 0;
  int           send_gap = 0;
  int           take_gap = 0;
  int           cycle_count = 0;

  // Pool of key/hash pairs so that sequences revisit stored keys.
  logic [31:0]  pool_key [64];
  logic [31:0]  pool_hash [64];

  double_hash_open_address_table_core uut (.*);

  always #1 clk = ~clk;

  function automatic int random_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Work out the reply to one operation and update the shadow table.
  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t rep;
    int unsigned pos, stride, prime, tomb, n, found;
    bit have_tomb, placed, dup;
    rep.status = ST_NOT_FOUND;
    rep.bucket = '0;
    prime = (shadow_step_prime == 0) ? 1 : shadow_step_prime;
    pos = op.key_hash % NUM_BUCKETS;
    stride = (prime - (op.key_hash % prime)) % NUM_BUCKETS;
    have_tomb = 0;
    placed = 0;
    dup = 0;
    tomb = 0;
    found = 0;
    if (op.mode == MODE_INSERT) begin
      if (shadow_count > shadow_max_fill) begin
        rep.status = ST_FULL;
      end else begin
        for (n = 0; n < NUM_BUCKETS; n++) begin
          if (shadow_mark[pos] == MARK_EMPTY) begin
            found = have_tomb ? tomb : pos;
            placed = 1;
            break;
          end else if (shadow_mark[pos] == MARK_TOMB) begin
            if (!have_tomb) begin
              have_tomb = 1;
              tomb = pos;
            end
          end else if (shadow_key[pos] == op.key) begin
            dup = 1;
            found = pos;
            break;
          end
          pos = (pos + stride) % NUM_BUCKETS;
        end
        if (dup) begin
          rep.status = ST_DUPLICATE;
          rep.bucket = 10'(found);
        end else begin
          if (!placed && have_tomb) begin
            found = tomb;
            placed = 1;
          end
          if (placed) begin
            shadow_mark[found] = MARK_USED;
            shadow_key[found] = op.key;
            shadow_count++;
            rep.status = ST_INSERTED;
            rep.bucket = 10'(found);
          end else begin
            rep.status = ST_FULL;
          end
        end
      end
    end else if (shadow_count != 0) begin
      // Remove and lookup (mode three acts as lookup) share the search.
      for (n = 0; n < NUM_BUCKETS; n++) begin
        if (shadow_mark[pos] == MARK_EMPTY) break;
        if (shadow_mark[pos] == MARK_USED && shadow_key[pos] == op.key) begin
          rep.bucket = 10'(pos);
          if (op.mode == MODE_REMOVE) begin
            shadow_mark[pos] = MARK_TOMB;
            shadow_count--;
            rep.status = ST_REMOVED;
          end else begin
            rep.status = ST_FOUND;
          end
          break;
        end
        pos = (pos + stride) % NUM_BUCKETS;
      end
    end
    rep.count = shadow_count[9:0];
    return rep;
  endfunction

  // Driver: offers queued operations and predicts each accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(apply_table_op(pending_ops.pop_front()));
        send_gap = random_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, pending_ops[0].key_hash, pending_ops[0].key,
                         pending_ops[0].mode};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      cycle_count = 0;
    end else begin
      cycle_count++;
      if (cycle_count >= 3000 && cycle_count < 3600) begin
        m_axis_tready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        take_gap = random_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        failures++;
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata[2:0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_axis_tdata[2:0]);
          failures++;
        end
        if (m_axis_tdata[12:3] !== want.bucket) begin
          $display("%0t: bucket expected %0d actual %0d", $time, want.bucket,
                   m_axis_tdata[12:3]);
          failures++;
        end
        if (m_axis_tdata[22:13] !== want.count) begin
          $display("%0t: stored_count expected %0d actual %0d", $time, want.count,
                   m_axis_tdata[22:13]);
          failures++;
        end
      end
    end
  end

  task automatic queue_op(logic [1:0] mode, logic [31:0] key, logic [31:0] key_hash);
    table_op_t op;
    op.mode = mode;
    op.key = key;
    op.key_hash = key_hash;
    @(negedge clk);
    pending_ops.push_back(op);
  endtask

  // Waits until every queued operation has been answered, then lets the core settle.
  task automatic drain();
    wait (pending_ops.size() == 0 && expected_replies.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [9:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == CFG_STEP_PRIME) shadow_step_prime = value;
    else shadow_max_fill = value;
  endtask

  // Mostly pool keys in a realistic mix, some fully random noise.
  task automatic random_ops(int count);
    int r, p;
    logic [1:0] mode;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40) mode = MODE_INSERT;
      else if (r < 65) mode = MODE_REMOVE;
      else if (r < 95) mode = MODE_LOOKUP;
      else mode = 2'd3;
      if ($urandom_range(99) < 85) begin
        p = $urandom_range(63);
        queue_op(mode, pool_key[p], pool_hash[p]);
      end else begin
        queue_op(mode, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      shadow_mark[i] = MARK_EMPTY;
      shadow_key[i] = '0;
    end
    for (int i = 0; i < 64; i++) begin
      pool_key[i] = $urandom;
      pool_hash[i] = (i < 32) ? $urandom : $urandom_range(3000);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, collisions, tombstones and odd mode.
    queue_op(MODE_LOOKUP, 32'd0, 32'd0);
    queue_op(MODE_REMOVE, 32'd0, 32'd0);
    queue_op(MODE_INSERT, 32'd0, 32'd0);
    queue_op(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(MODE_INSERT, 32'd0, 32'd0);
    queue_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(MODE_LOOKUP, 32'd5, 32'd0);
    queue_op(MODE_INSERT, 32'd5, 32'd0);
    queue_op(MODE_INSERT, 32'd6, 32'd1021);
    queue_op(MODE_REMOVE, 32'd0, 32'd0);
    queue_op(MODE_LOOKUP, 32'd5, 32'd0);
    queue_op(MODE_INSERT, 32'd6, 32'd1021);
    queue_op(MODE_INSERT, 32'd7, 32'd0);
    queue_op(2'd3, 32'd7, 32'd0);
    queue_op(MODE_REMOVE, 32'd99, 32'd0);
    queue_op(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Short step, high fill limit.
    write_reg(CFG_STEP_PRIME, 10'd2);
    write_reg(CFG_MAX_FILL, 10'd1021);
    random_ops(250);
    drain();

    // Low fill limit, so inserts are refused as full even for stored keys.
    write_reg(CFG_STEP_PRIME, 10'd1019);
    write_reg(CFG_MAX_FILL, 10'd1);
    random_ops(120);
    drain();

    // Step prime of zero acts as one; fill limit at its top code.
    write_reg(CFG_STEP_PRIME, 10'd0);
    write_reg(CFG_MAX_FILL, 10'd1023);
    random_ops(180);
    drain();

    // A step that is a multiple of the size keeps the probe on one bucket.
    write_reg(CFG_STEP_PRIME, 10'd1023);
    write_reg(CFG_MAX_FILL, 10'd600);
    queue_op(MODE_LOOKUP, 32'h1234_5678, 32'd2);
    queue_op(MODE_INSERT, 32'h1234_5678, 32'd2);
    queue_op(MODE_REMOVE, 32'h1234_5678, 32'd2);
    queue_op(MODE_INSERT, 32'h0BAD_F00D, 32'd2);
    random_ops(120);
    drain();

    // Back to the reset settings.
    write_reg(CFG_STEP_PRIME, 10'd29);
    write_reg(CFG_MAX_FILL, 10'd510);
    random_ops(230);
    drain();

    if (failures == 0) begin
      $display("double_hash_open_address_table_core regression: pass");
    end else begin
      $display("double_hash_open_address_table_core regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("double_hash_open_address_table_core regression: fail");
    $finish;
  end

endmodule
